>>> design/cvw_pkg.sv
// Package for the codec volume register writer.
// Holds the microcode types, codes, control structs and the fixed tables.
// No dependencies.
`timescale 1ns / 1ps

package cvw_pkg;

  localparam int ADDR_W = 7;
  localparam int VALUE_W = 9;
  localparam int LEVEL_W = 7;
  localparam int CALC_W = 10;

  localparam logic signed [CALC_W-1:0] BASE_LEVEL = 10'sd121;
  localparam logic signed [CALC_W-1:0] LEVEL_MAX = 10'sd127;
  localparam logic [LEVEL_W-1:0] LEVEL_CLAMP = 7'h7F;
  localparam logic [VALUE_W-1:0] UPDATE_LATCH = 9'h080;
  localparam logic [VALUE_W-1:0] UPDATE_BOTH = 9'h180;

  localparam logic [ADDR_W-1:0] REG_HP_LEFT = 7'd2;
  localparam logic [ADDR_W-1:0] REG_HP_RIGHT = 7'd3;
  localparam logic [ADDR_W-1:0] REG_SP_LEFT = 7'd40;
  localparam logic [ADDR_W-1:0] REG_SP_RIGHT = 7'd41;

  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_STATUS = 1'b1;
  localparam logic OP_VOLUME = 1'b0;

  typedef logic [3:0] step_t;

  localparam step_t STEP_DISPATCH = 4'd0;
  localparam step_t STEP_LEVELS = 4'd1;
  localparam step_t STEP_LOAD_HPL = 4'd2;
  localparam step_t STEP_LOAD_HPR = 4'd3;
  localparam step_t STEP_LOAD_SPL = 4'd4;
  localparam step_t STEP_LOAD_SPR = 4'd5;
  localparam step_t STEP_LOAD_RAW = 4'd6;
  localparam step_t STEP_CHECK = 4'd7;
  localparam step_t STEP_COMPARE = 4'd8;
  localparam step_t STEP_FINISH = 4'd9;

  typedef enum logic [1:0] {
    ST_OK,
    ST_BAD_INDEX,
    ST_BAD_LEVEL
  } status_t;

  typedef enum logic [1:0] {
    CFG_VOLUME_OFFSET,
    CFG_OUTPUT_MUTED,
    CFG_CODEC_READY
  } cfg_reg_t;

  typedef enum logic [2:0] {
    UOP_DISPATCH,
    UOP_LEVELS,
    UOP_LOAD,
    UOP_CHECK,
    UOP_COMPARE,
    UOP_FINISH
  } uop_t;

  typedef enum logic [2:0] {
    SEL_HP_LEFT,
    SEL_HP_RIGHT,
    SEL_SP_LEFT,
    SEL_SP_RIGHT,
    SEL_RAW
  } sel_t;

  typedef struct packed {
    uop_t  uop;
    sel_t  sel;
    step_t jump;
    step_t ret;
  } ucode_t;

  typedef struct packed {
    logic run;
    uop_t uop;
    sel_t sel;
  } ctrl_t;

  typedef struct packed {
    logic raw;
    logic index_bad;
    logic level_bad;
    logic addr_bad;
  } flags_t;

  function automatic logic [LEVEL_W-1:0] hp_atten(input logic [4:0] t);
    logic [LEVEL_W-1:0] v;
    case (t)
      5'd0:  v = 7'h7F;  5'd1:  v = 7'h49;  5'd2:  v = 7'h46;  5'd3:  v = 7'h42;
      5'd4:  v = 7'h3D;  5'd5:  v = 7'h3B;  5'd6:  v = 7'h39;  5'd7:  v = 7'h37;
      5'd8:  v = 7'h35;  5'd9:  v = 7'h33;  5'd10: v = 7'h31;  5'd11: v = 7'h2F;
      5'd12: v = 7'h2D;  5'd13: v = 7'h2B;  5'd14: v = 7'h29;  5'd15: v = 7'h27;
      5'd16: v = 7'h25;  5'd17: v = 7'h23;  5'd18: v = 7'h21;  5'd19: v = 7'h1F;
      5'd20: v = 7'h1D;  5'd21: v = 7'h1B;  5'd22: v = 7'h19;  5'd23: v = 7'h17;
      5'd24: v = 7'h15;  5'd25: v = 7'h13;  5'd26: v = 7'h11;  5'd27: v = 7'h0F;
      5'd28: v = 7'h0D;  5'd29: v = 7'h0B;  5'd30: v = 7'h09;
      default: v = 7'h7F;
    endcase
    return v;
  endfunction

  function automatic logic [LEVEL_W-1:0] sp_atten(input logic [4:0] t);
    logic [LEVEL_W-1:0] v;
    if (t == 5'd0) begin
      v = 7'h7F;
    end else begin
      v = 7'd31 - {2'b00, t};
    end
    return v;
  endfunction

  function automatic logic [VALUE_W-1:0] init_value(input logic [ADDR_W-1:0] a);
    logic [VALUE_W-1:0] v;
    case (a)
      7'd0:  v = 9'h097;  7'd1:  v = 9'h097;  7'd2:  v = 9'h180;  7'd3:  v = 9'h180;
      7'd7:  v = 9'h002;  7'd10: v = 9'h0FF;  7'd11: v = 9'h0FF;  7'd12: v = 9'h00F;
      7'd13: v = 9'h00F;  7'd17: v = 9'h07B;  7'd19: v = 9'h032;  7'd21: v = 9'h0C3;
      7'd22: v = 9'h0C3;  7'd23: v = 9'h0C1;  7'd25: v = 9'h1C0;  7'd26: v = 9'h060;
      7'd28: v = 9'h094;  7'd32: v = 9'h128;  7'd33: v = 9'h108;  7'd34: v = 9'h100;
      7'd35: v = 9'h050;  7'd36: v = 9'h050;  7'd37: v = 9'h100;  7'd38: v = 9'h050;
      7'd39: v = 9'h050;  7'd40: v = 9'h180;  7'd41: v = 9'h180;  7'd42: v = 9'h079;
      default: v = 9'h000;
    endcase
    return v;
  endfunction

endpackage

>>> design/cvw_ucode_rom.sv
// Microcode store of the codec volume register writer.
// One control word per step; depends on cvw_pkg.
`timescale 1ns / 1ps

module cvw_ucode_rom (
  input  cvw_pkg::step_t  pc,
  output cvw_pkg::ucode_t word
);

  always_comb begin
    case (pc)
      cvw_pkg::STEP_DISPATCH: word = '{cvw_pkg::UOP_DISPATCH, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_LOAD_RAW, cvw_pkg::STEP_FINISH};
      cvw_pkg::STEP_LEVELS:   word = '{cvw_pkg::UOP_LEVELS, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_FINISH, cvw_pkg::STEP_FINISH};
      cvw_pkg::STEP_LOAD_HPL: word = '{cvw_pkg::UOP_LOAD, cvw_pkg::SEL_HP_LEFT,
                                       cvw_pkg::STEP_CHECK, cvw_pkg::STEP_LOAD_HPR};
      cvw_pkg::STEP_LOAD_HPR: word = '{cvw_pkg::UOP_LOAD, cvw_pkg::SEL_HP_RIGHT,
                                       cvw_pkg::STEP_CHECK, cvw_pkg::STEP_LOAD_SPL};
      cvw_pkg::STEP_LOAD_SPL: word = '{cvw_pkg::UOP_LOAD, cvw_pkg::SEL_SP_LEFT,
                                       cvw_pkg::STEP_CHECK, cvw_pkg::STEP_LOAD_SPR};
      cvw_pkg::STEP_LOAD_SPR: word = '{cvw_pkg::UOP_LOAD, cvw_pkg::SEL_SP_RIGHT,
                                       cvw_pkg::STEP_CHECK, cvw_pkg::STEP_FINISH};
      cvw_pkg::STEP_LOAD_RAW: word = '{cvw_pkg::UOP_LOAD, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_CHECK, cvw_pkg::STEP_FINISH};
      cvw_pkg::STEP_CHECK:    word = '{cvw_pkg::UOP_CHECK, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_FINISH, cvw_pkg::STEP_FINISH};
      cvw_pkg::STEP_COMPARE:  word = '{cvw_pkg::UOP_COMPARE, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_FINISH, cvw_pkg::STEP_FINISH};
      default:                word = '{cvw_pkg::UOP_FINISH, cvw_pkg::SEL_RAW,
                                       cvw_pkg::STEP_DISPATCH, cvw_pkg::STEP_FINISH};
    endcase
  end

endmodule

>>> design/cvw_sequencer.sv
// Step counter, return register and busy flag of the codec volume register writer.
// Depends on cvw_pkg and cvw_ucode_rom.
`timescale 1ns / 1ps

module cvw_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic            ready,
  input  cvw_pkg::flags_t flags,
  output logic            busy,
  output cvw_pkg::ctrl_t  ctrl
);

  cvw_pkg::step_t  pc;
  cvw_pkg::step_t  pc_next;
  cvw_pkg::step_t  ret;
  cvw_pkg::step_t  ret_next;
  logic            busy_next;
  cvw_pkg::ucode_t word;

  cvw_ucode_rom u_rom (
    .pc   (pc),
    .word (word)
  );

  always_comb begin
    pc_next = pc;
    ret_next = ret;
    busy_next = busy;
    if (!busy) begin
      if (start) begin
        busy_next = 1'b1;
        pc_next = cvw_pkg::STEP_DISPATCH;
      end
    end else begin
      case (word.uop)
        cvw_pkg::UOP_DISPATCH: begin
          if (flags.raw) begin
            pc_next = word.jump;
          end else if (flags.index_bad) begin
            pc_next = cvw_pkg::STEP_FINISH;
          end else begin
            pc_next = pc + 4'd1;
          end
        end
        cvw_pkg::UOP_LEVELS: begin
          pc_next = flags.level_bad ? word.jump : pc + 4'd1;
        end
        cvw_pkg::UOP_LOAD: begin
          ret_next = word.ret;
          pc_next = word.jump;
        end
        cvw_pkg::UOP_CHECK: begin
          if (flags.addr_bad) begin
            pc_next = cvw_pkg::STEP_FINISH;
          end else if (!ready) begin
            pc_next = ret;
          end else begin
            pc_next = pc + 4'd1;
          end
        end
        cvw_pkg::UOP_COMPARE: begin
          pc_next = ret;
        end
        default: begin
          busy_next = 1'b0;
          pc_next = cvw_pkg::STEP_DISPATCH;
        end
      endcase
    end
  end

  always_comb begin
    ctrl.run = busy;
    ctrl.uop = word.uop;
    ctrl.sel = word.sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pc <= cvw_pkg::STEP_DISPATCH;
      ret <= cvw_pkg::STEP_FINISH;
    end else begin
      busy <= busy_next;
      pc <= pc_next;
      ret <= ret_next;
    end
  end

endmodule

>>> design/cvw_shadow_mem.sv
// Shadow copy of the codec registers: a single-port memory with registered read.
// Entries never written read as the codec's power-up image; depends on cvw_pkg.
`timescale 1ns / 1ps

module cvw_shadow_mem #(
  parameter int REGISTER_COUNT = 43
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic                        wr_en,
  input  logic [cvw_pkg::ADDR_W-1:0]  addr,
  input  logic [cvw_pkg::VALUE_W-1:0] wdata,
  output logic [cvw_pkg::VALUE_W-1:0] rdata
);

  localparam int IDX_W = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;

  logic [cvw_pkg::VALUE_W-1:0] mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0]   written;
  logic [cvw_pkg::VALUE_W-1:0] rd_data;
  logic [cvw_pkg::VALUE_W-1:0] rd_init;
  logic                        rd_written;
  logic [IDX_W-1:0]            idx;

  assign idx = addr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[idx] <= wdata;
    end
    if (rd_en) begin
      rd_data <= mem[idx];
      rd_init <= cvw_pkg::init_value(addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
      rd_written <= 1'b0;
    end else begin
      if (wr_en) begin
        written[idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_written <= written[idx];
      end
    end
  end

  assign rdata = rd_written ? rd_data : rd_init;

endmodule

>>> design/cvw_datapath.sv
// Datapath of the codec volume register writer: level arithmetic, frame and status
// registers, driven by the microcode control word. Depends on cvw_pkg.
`timescale 1ns / 1ps

module cvw_datapath #(
  parameter int REGISTER_COUNT = 43,
  parameter int VOLUME_STEPS = 31
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        load,
  input  logic                        operation,
  input  logic [4:0]                  volume_index,
  input  logic [5:0]                  reg_address,
  input  logic [8:0]                  reg_value,
  input  logic signed [7:0]           volume_offset,
  input  logic                        output_muted,
  input  cvw_pkg::ctrl_t              ctrl,
  input  logic [cvw_pkg::VALUE_W-1:0] shadow_rdata,
  output cvw_pkg::flags_t             flags,
  output logic                        shadow_rd_en,
  output logic                        shadow_wr_en,
  output logic [cvw_pkg::ADDR_W-1:0]  shadow_addr,
  output logic [cvw_pkg::VALUE_W-1:0] shadow_wdata,
  output logic                        strobe,
  output logic                        result_kind,
  output logic [7:0]                  frame_first_byte,
  output logic [7:0]                  frame_second_byte,
  output logic [1:0]                  status,
  output logic                        last
);

  logic                               op_raw;
  logic [4:0]                         idx;
  logic [5:0]                         raddr;
  logic [8:0]                         rval;
  logic [cvw_pkg::LEVEL_W-1:0]        hp;
  logic [cvw_pkg::LEVEL_W-1:0]        sp;
  logic [cvw_pkg::ADDR_W-1:0]         addr;
  logic [cvw_pkg::VALUE_W-1:0]        val;
  cvw_pkg::status_t                   st;
  logic [4:0]                         tbl_idx;
  logic signed [cvw_pkg::CALC_W-1:0]  off_ext;
  logic signed [cvw_pkg::CALC_W-1:0]  hp_raw;
  logic signed [cvw_pkg::CALC_W-1:0]  sp_raw;
  logic [cvw_pkg::LEVEL_W-1:0]        hp_calc;
  logic [cvw_pkg::LEVEL_W-1:0]        sp_calc;
  logic [cvw_pkg::ADDR_W-1:0]         addr_sel;
  logic [cvw_pkg::VALUE_W-1:0]        val_sel;
  logic                               step_check;
  logic                               step_compare;
  logic                               differs;

  assign tbl_idx = output_muted ? 5'd0 : idx;
  assign off_ext = $signed({{2{volume_offset[7]}}, volume_offset});
  assign hp_raw = cvw_pkg::BASE_LEVEL + off_ext
                  - $signed({3'b000, cvw_pkg::hp_atten(tbl_idx)});
  assign sp_raw = cvw_pkg::BASE_LEVEL + off_ext
                  - $signed({3'b000, cvw_pkg::sp_atten(tbl_idx)});

  always_comb begin
    hp_calc = hp_raw[9] ? '0 : hp_raw[cvw_pkg::LEVEL_W-1:0];
    if (sp_raw[9]) begin
      sp_calc = '0;
    end else if (sp_raw > cvw_pkg::LEVEL_MAX) begin
      sp_calc = cvw_pkg::LEVEL_CLAMP;
    end else begin
      sp_calc = sp_raw[cvw_pkg::LEVEL_W-1:0];
    end
  end

  always_comb begin
    flags.raw = op_raw;
    flags.index_bad = {1'b0, idx} >= 6'(VOLUME_STEPS);
    flags.level_bad = hp_raw > cvw_pkg::LEVEL_MAX;
    flags.addr_bad = {1'b0, addr} >= 8'(REGISTER_COUNT);
  end

  always_comb begin
    case (ctrl.sel)
      cvw_pkg::SEL_HP_LEFT: begin
        addr_sel = cvw_pkg::REG_HP_LEFT;
        val_sel = {2'b00, hp} | cvw_pkg::UPDATE_LATCH;
      end
      cvw_pkg::SEL_HP_RIGHT: begin
        addr_sel = cvw_pkg::REG_HP_RIGHT;
        val_sel = {2'b00, hp} | cvw_pkg::UPDATE_BOTH;
      end
      cvw_pkg::SEL_SP_LEFT: begin
        addr_sel = cvw_pkg::REG_SP_LEFT;
        val_sel = {2'b00, sp} | cvw_pkg::UPDATE_LATCH;
      end
      cvw_pkg::SEL_SP_RIGHT: begin
        addr_sel = cvw_pkg::REG_SP_RIGHT;
        val_sel = {2'b00, sp} | cvw_pkg::UPDATE_BOTH;
      end
      default: begin
        addr_sel = {1'b0, raddr};
        val_sel = rval;
      end
    endcase
  end

  assign step_check = ctrl.run && ctrl.uop == cvw_pkg::UOP_CHECK;
  assign step_compare = ctrl.run && ctrl.uop == cvw_pkg::UOP_COMPARE;
  assign differs = shadow_rdata != val;
  assign shadow_rd_en = step_check && !flags.addr_bad;
  assign shadow_wr_en = step_compare && differs;
  assign shadow_addr = addr;
  assign shadow_wdata = val;

  always_ff @(posedge clk) begin
    if (load) begin
      op_raw <= operation != cvw_pkg::OP_VOLUME;
      idx <= volume_index;
      raddr <= reg_address;
      rval <= reg_value;
    end
    if (ctrl.run && ctrl.uop == cvw_pkg::UOP_LEVELS) begin
      hp <= hp_calc;
      sp <= sp_calc;
    end
    if (ctrl.run && ctrl.uop == cvw_pkg::UOP_LOAD) begin
      addr <= addr_sel;
      val <= val_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= cvw_pkg::ST_OK;
      strobe <= 1'b0;
      result_kind <= cvw_pkg::KIND_FRAME;
      frame_first_byte <= '0;
      frame_second_byte <= '0;
      status <= '0;
      last <= 1'b0;
    end else begin
      strobe <= 1'b0;
      if (load) begin
        st <= cvw_pkg::ST_OK;
      end else if (ctrl.run) begin
        case (ctrl.uop)
          cvw_pkg::UOP_DISPATCH: begin
            if (!op_raw && flags.index_bad) begin
              st <= cvw_pkg::ST_BAD_INDEX;
            end
          end
          cvw_pkg::UOP_LEVELS: begin
            if (flags.level_bad) begin
              st <= cvw_pkg::ST_BAD_LEVEL;
            end
          end
          cvw_pkg::UOP_CHECK: begin
            if (flags.addr_bad) begin
              st <= cvw_pkg::ST_BAD_INDEX;
            end
          end
          cvw_pkg::UOP_COMPARE: begin
            if (differs) begin
              strobe <= 1'b1;
              result_kind <= cvw_pkg::KIND_FRAME;
              frame_first_byte <= {addr, val[8]};
              frame_second_byte <= val[7:0];
              status <= cvw_pkg::ST_OK;
              last <= 1'b0;
            end
          end
          cvw_pkg::UOP_FINISH: begin
            strobe <= 1'b1;
            result_kind <= cvw_pkg::KIND_STATUS;
            frame_first_byte <= '0;
            frame_second_byte <= '0;
            status <= st;
            last <= 1'b1;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

>>> design/codec_volume_register_writer.sv
// Top level of the codec volume register writer: configuration registers and
// wiring of sequencer, datapath and shadow memory. Depends on cvw_pkg and all cvw_ modules.
`timescale 1ns / 1ps

//  channel   | handshake              | payload
//  ----------+------------------------+-------------------------------------------
//  command   | start, busy            | operation, volume_index, reg_address,
//            |                        | reg_value
//  result    | strobe                 | result_kind, frame_first_byte,
//            |                        | frame_second_byte, status, last
//  config    | cfg_valid, cfg_ready   | cfg_index, cfg_data
//
// A raw register write keeps busy high through dispatch, load, shadow read, compare and
// the status item, without compare when the address is out of range or the codec is not
// ready. A volume command takes dispatch and level steps, then load, shadow read and
// compare per register, then the status item; the single shadow port sets the write steps.
// Reset is synchronous; it clears the configuration and marks every shadow entry as
// holding the codec's power-up image. Results cannot be stalled: each item is shown
// for one cycle with strobe high. cfg_ready is always high.

module codec_volume_register_writer #(
  parameter int REGISTER_COUNT = 43,
  parameter int VOLUME_STEPS = 31
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       operation,
  input  logic [4:0] volume_index,
  input  logic [5:0] reg_address,
  input  logic [8:0] reg_value,
  output logic       strobe,
  output logic       result_kind,
  output logic [7:0] frame_first_byte,
  output logic [7:0] frame_second_byte,
  output logic [1:0] status,
  output logic       last,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  logic signed [7:0]            volume_offset;
  logic                         output_muted;
  logic                         codec_ready;
  cvw_pkg::flags_t              flags;
  cvw_pkg::ctrl_t               ctrl;
  logic                         load;
  logic                         shadow_rd_en;
  logic                         shadow_wr_en;
  logic [cvw_pkg::ADDR_W-1:0]   shadow_addr;
  logic [cvw_pkg::VALUE_W-1:0]  shadow_wdata;
  logic [cvw_pkg::VALUE_W-1:0]  shadow_rdata;

  assign cfg_ready = 1'b1;
  assign load = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_offset <= '0;
      output_muted <= 1'b0;
      codec_ready <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        cvw_pkg::CFG_VOLUME_OFFSET: volume_offset <= $signed(cfg_data);
        cvw_pkg::CFG_OUTPUT_MUTED:  output_muted <= cfg_data[0];
        cvw_pkg::CFG_CODEC_READY:   codec_ready <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  cvw_sequencer u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .ready (codec_ready),
    .flags (flags),
    .busy  (busy),
    .ctrl  (ctrl)
  );

  cvw_datapath #(
    .REGISTER_COUNT (REGISTER_COUNT),
    .VOLUME_STEPS   (VOLUME_STEPS)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .load              (load),
    .operation         (operation),
    .volume_index      (volume_index),
    .reg_address       (reg_address),
    .reg_value         (reg_value),
    .volume_offset     (volume_offset),
    .output_muted      (output_muted),
    .ctrl              (ctrl),
    .shadow_rdata      (shadow_rdata),
    .flags             (flags),
    .shadow_rd_en      (shadow_rd_en),
    .shadow_wr_en      (shadow_wr_en),
    .shadow_addr       (shadow_addr),
    .shadow_wdata      (shadow_wdata),
    .strobe            (strobe),
    .result_kind       (result_kind),
    .frame_first_byte  (frame_first_byte),
    .frame_second_byte (frame_second_byte),
    .status            (status),
    .last              (last)
  );

  cvw_shadow_mem #(
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_shadow (
    .clk   (clk),
    .rst   (rst),
    .rd_en (shadow_rd_en),
    .wr_en (shadow_wr_en),
    .addr  (shadow_addr),
    .wdata (shadow_wdata),
    .rdata (shadow_rdata)
  );

endmodule
